>>> rtl/assert_macros.svh
// Assertion helpers; the using module provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/lad_pkg.sv
`default_nettype none
package lad_pkg;

  // opcodes
  localparam logic [2:0] OP_INS_REAR  = 3'd0;
  localparam logic [2:0] OP_DEL_FRONT = 3'd1;
  localparam logic [2:0] OP_INS_FRONT = 3'd2;
  localparam logic [2:0] OP_DEL_REAR  = 3'd3;
  localparam logic [2:0] OP_READ_ALL  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOFRONT  = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] item_value;
  } lad_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               has_value;
    logic signed [31:0] out_value;
    logic               last;
  } lad_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic take;   // latch request
    logic exec;   // carry out latched opcode
    logic emit;   // load read data into response register
    logic step;   // advance read-out scan, issue next read
  } lad_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_read;
    logic read_last;
    logic out_free;
  } lad_sts_t;

endpackage
`default_nettype wire

>>> rtl/lad_ctrl.sv
`default_nettype none
module lad_ctrl
  import lad_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire lad_sts_t sts,
  output lad_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.needs_read) begin
          cmd.exec   = 1'b1;
          state_next = S_READ;
        end else if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.read_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lad_dp.sv
`default_nettype none
module lad_dp
  import lad_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire lad_req_t req,
  input  wire lad_cmd_t cmd,
  output lad_sts_t      sts,
  input  wire logic     rsp_ready,
  output logic          rsp_valid,
  output lad_rsp_t      rsp
);

  localparam int IW = $clog2(DEPTH + 1);  // index incl. DEPTH
  localparam int AW = $clog2(DEPTH);      // slot address

  logic signed [31:0] mem [DEPTH];

  logic [2:0]         op_q;
  logic signed [31:0] item_q;
  logic [IW-1:0]      front, rear1;
  logic [AW-1:0]      scan, last_addr;
  logic               single;
  logic signed [31:0] rd_data;

  logic [IW-1:0] front_inc, front_dec, rear_dec;
  logic [AW-1:0] scan_inc;
  logic          empty, rear_full;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [1:0]    res_status;
  logic          is_read_op;

  assign front_inc = front + IW'(1);
  assign front_dec = front - IW'(1);
  assign rear_dec  = rear1 - IW'(1);
  assign scan_inc  = scan + AW'(1);
  assign empty     = (front >= rear1);
  assign rear_full = (rear1 == IW'(DEPTH));

  assign is_read_op = (op_q == OP_DEL_FRONT) || (op_q == OP_DEL_REAR) ||
                      (op_q == OP_READ_ALL);

  assign sts.needs_read = is_read_op && !empty;
  assign sts.read_last  = single || (scan == last_addr);
  assign sts.out_free   = !rsp_valid || rsp_ready;

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = rear1[AW-1:0];
    rd_en      = 1'b0;
    rd_addr    = front[AW-1:0];
    res_status = ST_OK;
    case (op_q)
      OP_INS_REAR: begin
        if (rear_full) begin
          res_status = ST_OVERFLOW;
        end else begin
          wr_en = cmd.exec;
        end
      end
      OP_DEL_FRONT, OP_READ_ALL: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          rd_en = cmd.exec;
        end
      end
      OP_INS_FRONT: begin
        if (front == '0 && rear1 == '0) begin
          wr_en   = cmd.exec;
          wr_addr = '0;
        end else if (front != '0) begin
          wr_en   = cmd.exec;
          wr_addr = front_dec[AW-1:0];
        end else begin
          res_status = ST_NOFRONT;
        end
      end
      OP_DEL_REAR: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          rd_en   = cmd.exec;
          rd_addr = rear_dec[AW-1:0];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
    if (cmd.step) begin
      rd_en   = 1'b1;
      rd_addr = scan_inc;
    end
  end

  // element store, one write port and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // latched request and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q   <= req.opcode;
      item_q <= req.item_value;
    end
    if (cmd.exec) begin
      scan      <= front[AW-1:0];
      last_addr <= rear_dec[AW-1:0];
      single    <= (op_q != OP_READ_ALL);
    end else if (cmd.step) begin
      scan <= scan_inc;
    end
  end

  // queue indices
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear1 <= '0;
    end else if (cmd.exec) begin
      case (op_q)
        OP_INS_REAR: begin
          if (!rear_full) begin
            rear1 <= rear1 + IW'(1);
          end
        end
        OP_DEL_FRONT: begin
          if (!empty) begin
            if (front_inc >= rear1) begin
              front <= '0;
              rear1 <= '0;
            end else begin
              front <= front_inc;
            end
          end
        end
        OP_INS_FRONT: begin
          if (front == '0 && rear1 == '0) begin
            rear1 <= IW'(1);
          end else if (front != '0) begin
            front <= front_dec;
          end
        end
        OP_DEL_REAR: begin
          if (!empty) begin
            if (front >= rear_dec) begin
              front <= '0;
              rear1 <= '0;
            end else begin
              rear1 <= rear_dec;
            end
          end
        end
        default: begin
          front <= front;
        end
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((cmd.exec && !sts.needs_read) || cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status    <= ST_OK;
      rsp.has_value <= 1'b1;
      rsp.out_value <= rd_data;
      rsp.last      <= sts.read_last;
    end else if (cmd.exec && !sts.needs_read) begin
      rsp.status    <= res_status;
      rsp.has_value <= 1'b0;
      rsp.out_value <= '0;
      rsp.last      <= 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/linear_array_deque.sv
// Double-ended queue in a linear (non-wrapping) array of DEPTH signed words.
// Request channel (req_valid/req_ready/req): opcode plus item_value.
//   Opcodes: insert rear, delete front, insert front, delete rear, read out.
// Response channel (rsp_valid/rsp_ready/rsp): status, has_value, out_value,
//   last. Every transaction gives one response, except a read-out of a
//   non-empty queue, which streams one response per element, front to rear,
//   with last set on the final one.
// Order: an insert, an unused opcode or an error/empty response is loaded
//   into the response register when the request executes; a delete or a
//   read-out first reads the element store, then loads the response register.
// Throughput: one request in flight at a time; a read-out streams one
//   element per cycle while the response channel is not stalled.
// Stall: a held response holds back the next response; nothing is lost or repeated.
// Reset (rst, synchronous): front and rear indices clear to an empty queue.
//   The element store is not cleared; only written slots are ever read, so
//   no clearing pass is needed and a request can be taken right after reset.
`default_nettype none
module linear_array_deque
  import lad_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire lad_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output lad_rsp_t      rsp
);

  `include "assert_macros.svh"

  lad_cmd_t cmd;  // controller commands
  lad_sts_t sts;  // datapath status

  // sequencer: take, execute, stream reads
  lad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // indices, element store and response register
  lad_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // a taken request closes the request port
  `ASSERT_CLK(a_take_closes, (req_valid && req_ready) |=> !req_ready, "request port not closed")
  // a read result always shows up as a valued response
  `ASSERT_CLK(a_emit_valued, cmd.emit |=> (rsp_valid && rsp.has_value), "emitted value missing")
  // a stalled response is never overwritten
  `ASSERT_NEVER(a_no_overwrite, rsp_valid && !rsp_ready && (cmd.emit || (cmd.exec && !sts.needs_read)), "stalled response overwritten")

endmodule
`default_nettype wire

>>> test/linear_array_deque_test.sv
`timescale 1ns / 1ps

// Deque testbench: a queue of request transactions feeds a clocked driver,
// a clocked monitor checks every response against a predictor that tracks
// its own copy of the slots and the front/rear indices.
module linear_array_deque_test;
  import lad_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 180;
  localparam int QUIET_TAIL   = 30;      // final transactions run with no idling
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 8;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  lad_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  lad_rsp_t rsp;

  linear_array_deque #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // A queued request; hold makes the driver wait until all responses are in.
  typedef struct {
    lad_req_t req;
    bit       hold;
  } backlog_entry_t;

  backlog_entry_t req_backlog[$];
  lad_rsp_t       predicted_rsp[$];

  // Predictor state: live elements sit in slots front .. rear_next-1.
  logic signed [31:0] deque_slots [DEPTH];
  logic [4:0]         deque_front = '0;
  logic [4:0]         deque_rear_next = '0;

  int mismatches = 0;
  int cycle_count = 0;
  int tx_gap = 0;
  int rx_stall = 0;

  logic     nxt_valid;
  lad_req_t nxt_req;
  logic     nxt_ready;

  // Fewer than QUIET_TAIL items left: neither side starts a new idle spell.
  function automatic bit quiet_tail();
    return req_backlog.size() < QUIET_TAIL;
  endfunction

  // Work out the responses of one accepted request and queue them.
  task automatic deque_predict(input lad_req_t t);
    lad_rsp_t r;
    bit       streamed;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    streamed = 1'b0;
    case (t.opcode)
      OP_INS_REAR: begin
        if (deque_rear_next >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          deque_slots[deque_rear_next] = t.item_value;
          deque_rear_next++;
        end
      end
      OP_DEL_FRONT: begin
        if (deque_front >= deque_rear_next) begin
          r.status = ST_EMPTY;
        end else begin
          r.has_value = 1'b1;
          r.out_value = deque_slots[deque_front];
          deque_front++;
          if (deque_front >= deque_rear_next) begin
            deque_front = '0;
            deque_rear_next = '0;
          end
        end
      end
      OP_INS_FRONT: begin
        if (deque_front == 0 && deque_rear_next == 0) begin
          // empty queue: element lands in slot 0
          deque_slots[0] = t.item_value;
          deque_rear_next = 5'd1;
        end else if (deque_front != 0) begin
          deque_front--;
          deque_slots[deque_front] = t.item_value;
        end else begin
          r.status = ST_NOFRONT;
        end
      end
      OP_DEL_REAR: begin
        if (deque_front >= deque_rear_next) begin
          r.status = ST_EMPTY;
        end else begin
          deque_rear_next--;
          r.has_value = 1'b1;
          r.out_value = deque_slots[deque_rear_next];
          if (deque_front >= deque_rear_next) begin
            deque_front = '0;
            deque_rear_next = '0;
          end
        end
      end
      OP_READ_ALL: begin
        if (deque_front >= deque_rear_next) begin
          r.status = ST_EMPTY;
        end else begin
          streamed = 1'b1;
          for (int i = deque_front; i < deque_rear_next; i++) begin
            r.has_value = 1'b1;
            r.out_value = deque_slots[i];
            r.last = (i + 1 == deque_rear_next);
            predicted_rsp.push_back(r);
          end
        end
      end
      default: ;  // unused opcodes: no state change, plain ok response
    endcase
    if (!streamed) predicted_rsp.push_back(r);
  endtask

  task automatic queue_req(input logic [2:0] op, input logic signed [31:0] val);
    backlog_entry_t e;
    e.req.opcode = op;
    e.req.item_value = val;
    // a couple of points where the sender waits for the block to drain
    e.hold = (req_backlog.size() == 40 || req_backlog.size() == 120);
    req_backlog.push_back(e);
  endtask

  // Random value, biased toward the corners of the 32-bit signed range.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $signed($urandom);
    endcase
  endfunction

  // Driver: presents one transaction at a time, predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      nxt_valid = req_valid;
      nxt_req = req;
      if (req_valid && req_ready) begin
        deque_predict(req);
        nxt_valid = 1'b0;
        if (!quiet_tail() && $urandom_range(0, 3) == 0) tx_gap = $urandom_range(1, 8);
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (req_backlog.size() > 0 &&
                     (!req_backlog[0].hold || predicted_rsp.size() == 0)) begin
          nxt_valid = 1'b1;
          nxt_req = req_backlog[0].req;
          req_backlog.pop_front();
        end
      end
      // single update per edge; valid stays high back to back
      req_valid <= nxt_valid;
      req <= nxt_req;
    end
  end

  // Monitor: check each response transaction, then pick the next ready.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (predicted_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response: status %0d has_value %0b value %0d last %0b",
                     rsp.status, rsp.has_value, rsp.out_value, rsp.last);
        end else begin
          if (rsp.status !== predicted_rsp[0].status ||
              rsp.has_value !== predicted_rsp[0].has_value ||
              rsp.out_value !== predicted_rsp[0].out_value ||
              rsp.last !== predicted_rsp[0].last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp status %0d has %0b value %0d last %0b, got %0d %0b %0d %0b",
                       predicted_rsp[0].status, predicted_rsp[0].has_value,
                       predicted_rsp[0].out_value, predicted_rsp[0].last,
                       rsp.status, rsp.has_value, rsp.out_value, rsp.last);
          end
          predicted_rsp.pop_front();
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        nxt_ready = 1'b0;
      end else if (!quiet_tail() && $urandom_range(0, 9) == 0) begin
        rx_stall = $urandom_range(0, 7);  // start a stall burst of random length
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      rsp_ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int n;
    int target;

    // Directed: empty cases, front insertion rules, read-out, odd opcodes.
    queue_req(OP_DEL_FRONT, 32'sd0);
    queue_req(OP_DEL_REAR, 32'sd0);
    queue_req(OP_READ_ALL, 32'sd0);
    queue_req(OP_INS_FRONT, 32'sh7fff_ffff);   // into empty queue -> slot 0
    queue_req(OP_INS_FRONT, 32'sd5);           // front at 0, not empty: blocked
    queue_req(OP_INS_REAR, 32'sh8000_0000);
    queue_req(OP_INS_REAR, -32'sd1);
    queue_req(OP_DEL_FRONT, 32'sd0);           // front moves to 1
    queue_req(OP_INS_FRONT, 32'sd0);           // front back to 0
    queue_req(OP_READ_ALL, 32'sd0);
    queue_req(OP_DEL_REAR, 32'sd0);
    queue_req(3'd5, 32'sh1234_5678);
    queue_req(3'd6, -32'sd1);
    queue_req(3'd7, 32'sh7fff_ffff);
    queue_req(OP_DEL_FRONT, 32'sd0);
    queue_req(OP_DEL_REAR, 32'sd0);            // empties, indices back to start
    queue_req(OP_READ_ALL, 32'sd0);

    // Random: mostly structured sequences, some noise.
    target = req_backlog.size() + RANDOM_ITEMS;
    while (req_backlog.size() < target) begin
      case ($urandom_range(0, 3))
        0: begin
          repeat ($urandom_range(1, 4)) queue_req($urandom_range(0, 7), pick_value());
        end
        1: begin
          // fill toward the rear limit, often past it, then read out
          repeat ($urandom_range(1, 18)) queue_req(OP_INS_REAR, pick_value());
          queue_req(OP_READ_ALL, pick_value());
        end
        2: begin
          // open room at the front and refill it
          n = $urandom_range(1, 5);
          repeat (n) queue_req(OP_DEL_FRONT, pick_value());
          repeat ($urandom_range(1, n + 1)) queue_req(OP_INS_FRONT, pick_value());
          queue_req(OP_READ_ALL, pick_value());
        end
        default: begin
          repeat ($urandom_range(1, 10))
            queue_req($urandom_range(0, 1) ? OP_DEL_FRONT : OP_DEL_REAR, pick_value());
        end
      endcase
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (req_backlog.size() > 0 || req_valid) @(posedge clk);
    while (predicted_rsp.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/lad_pkg.sv
rtl/lad_ctrl.sv
rtl/lad_dp.sv
rtl/linear_array_deque.sv
test/linear_array_deque_test.sv
